// ----- design/swtc_pkg.sv -----
// Shared types and constants for the set-associative write-through cache.
// No dependencies; the front end, back end and top level refer to this package by scope.
`default_nettype none

package swtc_pkg;

  // Item class, settled by the front end
  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_FILL,
    OP_BAD
  } op_t;

  // Input mode codes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_FILL  = 2'd2;

  // Result kind codes
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_FETCH  = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  // Legal access lengths
  localparam logic [2:0] LEN_MIN = 3'd1;
  localparam logic [2:0] LEN_MAX = 3'd4;

  // Replacement LFSR seed
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  // Queue entry: classified item
  typedef struct packed {
    op_t         op;
    logic [31:0] addr;   // masked to the address width
    logic [2:0]  len;
    logic [31:0] data;   // write bytes (trimmed to len) or fill word
    logic [2:0]  pn0;    // bytes in the first part
    logic        two;    // access spans two blocks
  } entry_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // Back end status towards the front end
  typedef struct packed {
    logic pop;
    logic busy;
  } back_stat_t;

  // Back end sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_CMP,
    ST_BYTE,
    ST_BCAP,
    ST_FINISH,
    ST_REQ2,
    ST_REJ,
    ST_VICT_RD,
    ST_VICT_SEL,
    ST_VICT_MOD,
    ST_FILL,
    ST_RDONE
  } state_t;

endpackage

`default_nettype wire

// ----- design/swtc_in_if.sv -----
// Input channel interface: valid/ready handshake plus the access item.
// Stands alone; used by the top level and the front end.
`default_nettype none

interface swtc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] address;
  logic [2:0]  length;
  logic [31:0] write_data;
  logic [31:0] fill_word;

  modport source (output valid, output mode, output address, output length,
                  output write_data, output fill_word, input ready);
  modport sink   (input valid, input mode, input address, input length,
                  input write_data, input fill_word, output ready);
endinterface

`default_nettype wire

// ----- design/swtc_out_if.sv -----
// Result channel interface: valid/ready handshake plus one result item.
// Stands alone; used by the top level and the back end.
`default_nettype none

interface swtc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] out_address;
  logic [31:0] out_data;
  logic [2:0]  out_length;
  logic        last;

  modport source (output valid, output kind, output out_address, output out_data,
                  output out_length, output last, input ready);
  modport sink   (input valid, input kind, input out_address, input out_data,
                  input out_length, input last, output ready);
endinterface

`default_nettype wire

// ----- design/swtc_front.sv -----
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on swtc_pkg and swtc_in_if.
`default_nettype none

module swtc_front #(
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  swtc_in_if.sink              in_ch,
  input  swtc_pkg::back_stat_t stat,
  output swtc_pkg::head_t      head
);

  localparam int          OFF_W     = $clog2(LINE_BYTES);
  localparam logic [32:0] MASK_FULL = (33'd1 << ADDR_BITS) - 33'd1;
  localparam logic [31:0] ADDR_MASK = MASK_FULL[31:0];

  swtc_pkg::entry_t q_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;

  swtc_pkg::entry_t ent;
  logic             accept;
  logic             len_ok;
  logic [31:0]      addr_m;
  logic [31:0]      keep;
  logic [OFF_W:0]   room;

  // Classify the incoming item
  always_comb begin
    addr_m = in_ch.address & ADDR_MASK;
    len_ok = (in_ch.length >= swtc_pkg::LEN_MIN) && (in_ch.length <= swtc_pkg::LEN_MAX);
    keep   = (in_ch.length >= swtc_pkg::LEN_MAX) ? 32'hFFFF_FFFF
             : ((32'd1 << {in_ch.length, 3'b000}) - 32'd1);
    room   = (OFF_W + 1)'(LINE_BYTES) - {1'b0, addr_m[OFF_W-1:0]};
    case (in_ch.mode)
      swtc_pkg::MODE_READ:  ent.op = len_ok ? swtc_pkg::OP_READ : swtc_pkg::OP_BAD;
      swtc_pkg::MODE_WRITE: ent.op = len_ok ? swtc_pkg::OP_WRITE : swtc_pkg::OP_BAD;
      swtc_pkg::MODE_FILL:  ent.op = swtc_pkg::OP_FILL;
      default:              ent.op = swtc_pkg::OP_BAD;
    endcase
    ent.addr = addr_m;
    ent.len  = in_ch.length;
    ent.data = (in_ch.mode == swtc_pkg::MODE_FILL) ? in_ch.fill_word
               : (in_ch.write_data & keep);
    ent.pn0  = ((OFF_W + 1)'(in_ch.length) < room) ? in_ch.length : room[2:0];
    ent.two  = in_ch.length > ent.pn0;
  end

  assign in_ch.ready = (cnt_r != 2'd2) && !stat.busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign head.valid  = (cnt_r != 2'd0);
  assign head.entry  = q_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (accept) q_r[wr_ptr_r] <= ent;
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (accept)   wr_ptr_r <= ~wr_ptr_r;
      if (stat.pop) rd_ptr_r <= ~rd_ptr_r;
      case ({accept, stat.pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/swtc_back.sv -----
// Back end: tag/valid/data stores, lookup, refill and result sequencing.
// Depends on swtc_pkg and swtc_out_if.
`default_nettype none

module swtc_back #(
  parameter int LINE_BYTES = 64,
  parameter int NUM_WAYS   = 8,
  parameter int NUM_SETS   = 128,
  parameter int ADDR_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swtc_pkg::head_t      head,
  output swtc_pkg::back_stat_t stat,
  swtc_out_if.source           out_ch
);

  localparam int          OFF_W     = $clog2(LINE_BYTES);
  localparam int          WORDS     = LINE_BYTES / 4;
  localparam int          WRD_W     = $clog2(WORDS);
  localparam int          SET_BITS  = $clog2(NUM_SETS);
  localparam int          SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int          TAG_W     = ADDR_BITS - OFF_W - SET_BITS;
  localparam int          WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int          LINES     = NUM_SETS * NUM_WAYS;
  localparam int          LI_W      = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int          DEPTH     = LINES * WORDS;
  localparam int          DA_W      = $clog2(DEPTH);
  localparam logic [32:0] MASK_FULL = (33'd1 << ADDR_BITS) - 33'd1;
  localparam logic [31:0] ADDR_MASK = MASK_FULL[31:0];
  localparam logic [31:0] BLK_MASK  = ~(32'(LINE_BYTES - 1));
  // Reciprocal of the way count, exact for any 16-bit LFSR value
  localparam logic [20:0] RCP_M     = 21'(((1 << 20) + NUM_WAYS - 1) / NUM_WAYS);

  function automatic logic [SET_W-1:0] set_of(input logic [31:0] a);
    set_of = SET_W'((a >> OFF_W) & 32'(NUM_SETS - 1));
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
    tag_of = TAG_W'(a >> (OFF_W + SET_BITS));
  endfunction

  function automatic logic [DA_W-1:0] daddr(input logic [SET_W-1:0] s,
                                            input logic [WAY_W-1:0] w,
                                            input logic [WRD_W-1:0] wd);
    logic [LI_W-1:0] li;
    li    = LI_W'(s) * LI_W'(NUM_WAYS) + LI_W'(w);
    daddr = (DA_W'(li) << WRD_W) | DA_W'(wd);
  endfunction

  // Stores
  logic [NUM_WAYS-1:0] vmem [NUM_SETS];
  logic [NUM_WAYS-1:0] vrow_q;
  logic [TAG_W-1:0]    tmem [NUM_WAYS][NUM_SETS];
  logic [TAG_W-1:0]    trow_q [NUM_WAYS];
  logic [7:0]          dmem [4][DEPTH];
  logic [7:0]          dq [4];

  // Store controls
  logic                rd_en;
  logic [SET_W-1:0]    rd_set;
  logic                v_we;
  logic [SET_W-1:0]    v_wset;
  logic [NUM_WAYS-1:0] v_wrow;
  logic                t_we;
  logic [WAY_W-1:0]    t_wway;
  logic [SET_W-1:0]    t_wset;
  logic [TAG_W-1:0]    t_wtag;
  logic                d_re;
  logic [DA_W-1:0]     d_raddr;
  logic [3:0]          d_we;
  logic [DA_W-1:0]     d_waddr;
  logic [31:0]         d_wdata;

  // Sequencer and datapath registers
  swtc_pkg::state_t    state_r, state_nxt;
  swtc_pkg::entry_t    cur_r;
  logic                part_r;
  logic [1:0]          hit_r;
  logic [WAY_W-1:0]    way_r [2];
  logic [1:0]          byte_r;
  logic [31:0]         acc_r;
  logic [1:0]          mask_r;
  logic [31:0]         pend_addr_r;
  logic [2:0]          pend_len_r;
  logic [2:0]          pend_pn0_r;
  logic [WRD_W-1:0]    fill_cnt_r;
  logic [WAY_W-1:0]    fill_way_r;
  logic [15:0]         lfsr_r;
  logic [SET_W-1:0]    clr_r;

  // Output register
  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic [31:0]         out_addr_r;
  logic [31:0]         out_data_r;
  logic [2:0]          out_len_r;
  logic                out_last_r;

  // Emit request
  logic                emit_en;
  logic [1:0]          emit_kind;
  logic [31:0]         emit_addr;
  logic [31:0]         emit_data;
  logic [2:0]          emit_len;
  logic                emit_last;

  // Derived values
  logic                out_free;
  logic [31:0]         cur_pa1;
  logic [31:0]         look_addr;
  logic                pend_pp;
  logic [31:0]         pend_pa;
  logic                hit_any;
  logic [WAY_W-1:0]    hit_way;
  logic                inv_any;
  logic [WAY_W-1:0]    inv_way;
  logic [15:0]         lfsr_step;
  logic [36:0]         vic_prod;
  logic [15:0]         vic_q;
  logic [15:0]         vic_rem;
  logic                bpart;
  logic [OFF_W-1:0]    b_off;
  logic [SET_W-1:0]    b_set;
  logic                b_hit;
  logic                byte_last;
  logic                miss0;
  logic                miss1;
  logic                fill_last;
  logic [31:0]         fill_acc;
  logic [OFF_W-1:0]    f_off;
  logic                is_read;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign is_read   = (cur_r.op == swtc_pkg::OP_READ);
  assign cur_pa1   = (cur_r.addr + 32'(cur_r.pn0)) & ADDR_MASK;
  assign look_addr = part_r ? cur_pa1 : cur_r.addr;
  assign pend_pp   = !mask_r[0];
  assign pend_pa   = pend_pp ? ((pend_addr_r + 32'(pend_pn0_r)) & ADDR_MASK) : pend_addr_r;
  assign miss0     = !hit_r[0];
  assign miss1     = cur_r.two && !hit_r[1];
  assign fill_last = (fill_cnt_r == WRD_W'(WORDS - 1));
  assign lfsr_step = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};

  // Victim way: LFSR value modulo the way count by reciprocal multiplication
  assign vic_prod  = 37'(lfsr_r) * 37'(RCP_M);
  assign vic_q     = vic_prod[35:20];
  assign vic_rem   = lfsr_r - vic_q * 16'(NUM_WAYS);

  // Byte step of an access
  assign bpart     = (3'(byte_r) >= cur_r.pn0);
  assign b_off     = cur_r.addr[OFF_W-1:0] + OFF_W'(byte_r);
  assign b_set     = set_of(bpart ? cur_pa1 : cur_r.addr);
  assign b_hit     = hit_r[bpart];
  assign byte_last = (3'(byte_r) == cur_r.len - 3'd1);

  // Way compare on the registered set rows; lowest way wins
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (vrow_q[w] && trow_q[w] == tag_of(look_addr)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!vrow_q[w]) begin
        inv_any = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
  end

  // Pick the bytes of the pending part out of the current fill word
  always_comb begin
    fill_acc = acc_r;
    f_off    = '0;
    for (int i = 0; i < 4; i++) begin
      f_off = pend_addr_r[OFF_W-1:0] + OFF_W'(i);
      if ((3'(i) < pend_len_r) && ((3'(i) >= pend_pn0_r) == pend_pp)
          && (f_off[OFF_W-1:2] == fill_cnt_r)) begin
        fill_acc[8*i +: 8] = cur_r.data[8*f_off[1:0] +: 8];
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swtc_pkg::ST_INIT:
        if (clr_r == SET_W'(NUM_SETS - 1)) state_nxt = swtc_pkg::ST_IDLE;
      swtc_pkg::ST_IDLE:
        if (head.valid) begin
          if (mask_r != 2'b00) begin
            if (head.entry.op != swtc_pkg::OP_FILL) state_nxt = swtc_pkg::ST_REJ;
            else if (fill_cnt_r == '0)             state_nxt = swtc_pkg::ST_VICT_RD;
            else                                    state_nxt = swtc_pkg::ST_FILL;
          end else if (head.entry.op == swtc_pkg::OP_READ ||
                       head.entry.op == swtc_pkg::OP_WRITE) begin
            state_nxt = swtc_pkg::ST_LOOK;
          end else begin
            state_nxt = swtc_pkg::ST_REJ;
          end
        end
      swtc_pkg::ST_LOOK: state_nxt = swtc_pkg::ST_CMP;
      swtc_pkg::ST_CMP:
        state_nxt = (!part_r && cur_r.two) ? swtc_pkg::ST_LOOK : swtc_pkg::ST_BYTE;
      swtc_pkg::ST_BYTE:
        if (b_hit && is_read) state_nxt = swtc_pkg::ST_BCAP;
        else if (byte_last)   state_nxt = swtc_pkg::ST_FINISH;
      swtc_pkg::ST_BCAP:
        state_nxt = byte_last ? swtc_pkg::ST_FINISH : swtc_pkg::ST_BYTE;
      swtc_pkg::ST_FINISH:
        if (out_free)
          state_nxt = (is_read && miss0 && miss1) ? swtc_pkg::ST_REQ2 : swtc_pkg::ST_IDLE;
      swtc_pkg::ST_REQ2, swtc_pkg::ST_REJ, swtc_pkg::ST_RDONE:
        if (out_free) state_nxt = swtc_pkg::ST_IDLE;
      swtc_pkg::ST_VICT_RD: state_nxt = swtc_pkg::ST_VICT_SEL;
      swtc_pkg::ST_VICT_SEL:
        state_nxt = inv_any ? swtc_pkg::ST_FILL : swtc_pkg::ST_VICT_MOD;
      swtc_pkg::ST_VICT_MOD: state_nxt = swtc_pkg::ST_FILL;
      swtc_pkg::ST_FILL:
        state_nxt = (fill_last && !(!pend_pp && mask_r[1])) ? swtc_pkg::ST_RDONE
                    : swtc_pkg::ST_IDLE;
      default: state_nxt = swtc_pkg::ST_IDLE;
    endcase
  end

  // Store controls, queue pop and result requests
  always_comb begin
    stat.pop  = 1'b0;
    stat.busy = (state_r == swtc_pkg::ST_INIT);
    rd_en     = 1'b0;
    rd_set    = set_of(look_addr);
    v_we      = 1'b0;
    v_wset    = set_of(pend_pa);
    v_wrow    = vrow_q | (NUM_WAYS'(1) << fill_way_r);
    t_we      = 1'b0;
    t_wway    = fill_way_r;
    t_wset    = set_of(pend_pa);
    t_wtag    = tag_of(pend_pa);
    d_re      = 1'b0;
    d_raddr   = daddr(b_set, way_r[bpart], b_off[OFF_W-1:2]);
    d_we      = 4'b0000;
    d_waddr   = daddr(b_set, way_r[bpart], b_off[OFF_W-1:2]);
    d_wdata   = {4{cur_r.data[8*byte_r +: 8]}};
    emit_en   = 1'b0;
    emit_kind = swtc_pkg::KIND_REJECT;
    emit_addr = '0;
    emit_data = '0;
    emit_len  = '0;
    emit_last = 1'b1;
    case (state_r)
      swtc_pkg::ST_INIT: begin
        v_we   = 1'b1;
        v_wset = clr_r;
        v_wrow = '0;
      end
      swtc_pkg::ST_IDLE: stat.pop = head.valid;
      swtc_pkg::ST_LOOK: rd_en = 1'b1;
      swtc_pkg::ST_BYTE:
        if (b_hit) begin
          if (is_read) d_re = 1'b1;
          else         d_we[b_off[1:0]] = 1'b1;
        end
      swtc_pkg::ST_FINISH: begin
        emit_en = 1'b1;
        if (!is_read) begin
          emit_kind = swtc_pkg::KIND_WRITE;
          emit_addr = cur_r.addr;
          emit_data = cur_r.data;
          emit_len  = cur_r.len;
        end else if (miss0 || miss1) begin
          emit_kind = swtc_pkg::KIND_FETCH;
          emit_addr = (miss0 ? cur_r.addr : cur_pa1) & BLK_MASK;
          emit_last = !(miss0 && miss1);
        end else begin
          emit_kind = swtc_pkg::KIND_DATA;
          emit_addr = cur_r.addr;
          emit_data = acc_r;
          emit_len  = cur_r.len;
        end
      end
      swtc_pkg::ST_REQ2: begin
        emit_en   = 1'b1;
        emit_kind = swtc_pkg::KIND_FETCH;
        emit_addr = cur_pa1 & BLK_MASK;
      end
      swtc_pkg::ST_REJ: emit_en = 1'b1;
      swtc_pkg::ST_RDONE: begin
        emit_en   = 1'b1;
        emit_kind = swtc_pkg::KIND_DATA;
        emit_addr = pend_addr_r;
        emit_data = acc_r;
        emit_len  = pend_len_r;
      end
      swtc_pkg::ST_VICT_RD: begin
        rd_en  = 1'b1;
        rd_set = set_of(pend_pa);
      end
      swtc_pkg::ST_FILL: begin
        d_we    = 4'b1111;
        d_waddr = daddr(set_of(pend_pa), fill_way_r, fill_cnt_r);
        d_wdata = cur_r.data;
        t_we    = fill_last;
        v_we    = fill_last;
      end
      default: ;
    endcase
  end

  // Valid store: one row per set
  always_ff @(posedge clk) begin
    if (v_we) vmem[v_wset] <= v_wrow;
    if (rd_en) vrow_q <= vmem[rd_set];
  end

  // Tag store: one memory per way, read as a whole set
  always_ff @(posedge clk) begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (t_we && t_wway == WAY_W'(w)) tmem[w][t_wset] <= t_wtag;
      if (rd_en) trow_q[w] <= tmem[w][rd_set];
    end
  end

  // Data store: four byte lanes
  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      if (d_we[l]) dmem[l][d_waddr] <= d_wdata[8*l +: 8];
      if (d_re) dq[l] <= dmem[l][d_raddr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swtc_pkg::ST_INIT;
      clr_r       <= '0;
      mask_r      <= 2'b00;
      fill_cnt_r  <= '0;
      lfsr_r      <= swtc_pkg::LFSR_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == swtc_pkg::ST_INIT) clr_r <= clr_r + SET_W'(1);
      if (state_r == swtc_pkg::ST_FINISH && out_free && is_read && (miss0 || miss1)) begin
        mask_r     <= {miss1, miss0};
        fill_cnt_r <= '0;
      end
      if (state_r == swtc_pkg::ST_VICT_SEL && !inv_any) lfsr_r <= lfsr_step;
      if (state_r == swtc_pkg::ST_FILL) begin
        if (fill_last) begin
          mask_r[pend_pp] <= 1'b0;
          fill_cnt_r      <= '0;
        end else begin
          fill_cnt_r <= fill_cnt_r + WRD_W'(1);
        end
      end
      if (emit_en && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)   out_valid_r <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      swtc_pkg::ST_IDLE:
        if (head.valid) begin
          cur_r  <= head.entry;
          part_r <= 1'b0;
          byte_r <= 2'd0;
          if (mask_r == 2'b00 && head.entry.op == swtc_pkg::OP_READ) acc_r <= '0;
        end
      swtc_pkg::ST_CMP: begin
        hit_r[part_r] <= hit_any;
        way_r[part_r] <= hit_way;
        if (!part_r && cur_r.two) part_r <= 1'b1;
      end
      swtc_pkg::ST_BYTE:
        if (!(b_hit && is_read) && !byte_last) byte_r <= byte_r + 2'd1;
      swtc_pkg::ST_BCAP: begin
        acc_r[8*byte_r +: 8] <= dq[b_off[1:0]];
        if (!byte_last) byte_r <= byte_r + 2'd1;
      end
      swtc_pkg::ST_FINISH:
        if (out_free && is_read && (miss0 || miss1)) begin
          pend_addr_r <= cur_r.addr;
          pend_len_r  <= cur_r.len;
          pend_pn0_r  <= cur_r.pn0;
        end
      swtc_pkg::ST_VICT_SEL: fill_way_r <= inv_way;
      swtc_pkg::ST_VICT_MOD: fill_way_r <= vic_rem[WAY_W-1:0];
      swtc_pkg::ST_FILL: acc_r <= fill_acc;
      default: ;
    endcase
    if (emit_en && out_free) begin
      out_kind_r <= emit_kind;
      out_addr_r <= emit_addr;
      out_data_r <= emit_data;
      out_len_r  <= emit_len;
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.out_address = out_addr_r;
  assign out_ch.out_data    = out_data_r;
  assign out_ch.out_length  = out_len_r;
  assign out_ch.last        = out_last_r;

endmodule

`default_nettype wire

// ----- design/set_assoc_write_through_cache_top.sv -----
// Set-associative write-through cache, no write allocation: top level.
// Depends on swtc_pkg, swtc_in_if, swtc_out_if, swtc_front and swtc_back.
//
// Usage: items enter on in_ch (valid/ready); an item is taken when both are
// high. Mode 0 reads 1 to 4 bytes, mode 1 writes them through to memory,
// mode 2 delivers one refill word. Results leave on out_ch, one per
// handshake, with last set on the final result of an item.
// A two-entry queue sits between the front end and the sequencer, and the
// result register lets the front keep accepting while a result waits.
// Steps: a read looks up the set of each block it touches, then reads the
// data store once per hit byte; a write does the same lookups and writes
// each hit byte. The first refill word of a block first reads the victim
// set and picks a way, reducing the LFSR victim by a reciprocal multiply
// when every way is valid.
// Reset: the valid store is swept one set per cycle and in_ch.ready stays
// low until the sweep ends.
// When out_ch.ready is low the sequencer holds its result and stops; the
// queue fills and then in_ch.ready drops.
`default_nettype none

module set_assoc_write_through_cache_top #(
  parameter int LINE_BYTES = 64,
  parameter int NUM_WAYS   = 8,
  parameter int NUM_SETS   = 128,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  swtc_in_if.sink     in_ch,
  swtc_out_if.source  out_ch
);

  swtc_pkg::head_t      head;
  swtc_pkg::back_stat_t stat;

  // Accept and classify
  swtc_front #(
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .stat  (stat),
    .head  (head)
  );

  // Lookup, refill and results
  swtc_back #(
    .LINE_BYTES (LINE_BYTES),
    .NUM_WAYS   (NUM_WAYS),
    .NUM_SETS   (NUM_SETS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .stat   (stat),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ----- sim/set_assoc_write_through_cache_top_tb.sv -----
// Testbench for the set-associative write-through cache top level.
// Depends on swtc_pkg, swtc_in_if, swtc_out_if and the design files; a local
// cache model predicts every result item, which a monitor checks in order.
`default_nettype none

module set_assoc_write_through_cache_top_tb;

  localparam int LB    = 64;
  localparam int WAYS  = 8;
  localparam int SETS  = 128;
  localparam int WPL   = LB / 4;
  localparam int LINES = WAYS * SETS;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [2:0]  length;
    logic [31:0] write_data;
    logic [31:0] fill_word;
  } access_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic [2:0]  len;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  swtc_in_if  in_ch ();
  swtc_out_if out_ch ();

  set_assoc_write_through_cache_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state
  logic        cl_valid [LINES];
  logic [18:0] cl_tag   [LINES];
  logic [31:0] cl_data  [LINES*WPL];
  logic [15:0] lfsr;
  logic [31:0] pend_addr, pend_data;
  logic [2:0]  pend_len;
  logic [1:0]  miss_mask;
  int          fill_cnt;
  logic [31:0] fill_buf [WPL];

  access_t pending_items[$];
  result_t expected_results[$];
  int      errors = 0;
  bit      stim_done = 0;
  bit      calm = 0;

  task automatic report(input string what, input result_t got, input result_t exp_r);
    $display("MISMATCH %s: got k%0d a%h d%h n%0d l%0d, exp k%0d a%h d%h n%0d l%0d", what,
             got.kind, got.addr, got.data, got.len, got.last,
             exp_r.kind, exp_r.addr, exp_r.data, exp_r.len, exp_r.last);
    errors++;
  endtask

  function automatic void push_res(logic [1:0] k, logic [31:0] a, logic [31:0] d,
                                   logic [2:0] n, logic l);
    result_t r;
    r.kind = k; r.addr = a; r.data = d; r.len = n; r.last = l;
    expected_results.push_back(r);
  endfunction

  function automatic int find_way(logic [31:0] a);
    int s;
    s = (a / LB) % SETS;
    for (int w = 0; w < WAYS; w++)
      if (cl_valid[s*WAYS+w] && cl_tag[s*WAYS+w] == 19'((a / LB) / SETS)) return s*WAYS + w;
    return -1;
  endfunction

  // Byte copy between a line and a 32-bit access word
  function automatic void line_to_word(int li, int off, int n, int pos, inout logic [31:0] dst);
    for (int i = 0; i < n; i++)
      dst[8*((pos+i)%4) +: 8] = cl_data[li*WPL + (off+i)/4][8*((off+i)%4) +: 8];
  endfunction

  function automatic void word_to_line(int li, int off, int n, int pos, logic [31:0] src);
    for (int i = 0; i < n; i++)
      cl_data[li*WPL + (off+i)/4][8*((off+i)%4) +: 8] = src[8*((pos+i)%4) +: 8];
  endfunction

  function automatic int install_line(logic [31:0] a);
    int s, way;
    s = (a / LB) % SETS;
    way = -1;
    for (int w = 0; w < WAYS; w++)
      if (way < 0 && !cl_valid[s*WAYS+w]) way = w;
    if (way < 0) begin
      lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
      way = lfsr % WAYS;
    end
    for (int w = 0; w < WPL; w++) cl_data[(s*WAYS+way)*WPL + w] = fill_buf[w];
    cl_tag[s*WAYS+way] = 19'((a / LB) / SETS);
    cl_valid[s*WAYS+way] = 1'b1;
    return s*WAYS + way;
  endfunction

  // Predict the result items caused by one accepted item
  function automatic void predict_cache(access_t it);
    logic [31:0] pa[2];
    int pn[2], parts, li, part, len;
    len = it.length;
    if (miss_mask != 0) begin
      if (it.mode != swtc_pkg::MODE_FILL) begin
        push_res(swtc_pkg::KIND_REJECT, 0, 0, 0, 1);
        return;
      end
      fill_buf[fill_cnt] = it.fill_word;
      fill_cnt++;
      if (fill_cnt < WPL) return;
      fill_cnt = 0;
      pn[0] = (pend_len < LB - pend_addr % LB) ? pend_len : LB - pend_addr % LB;
      pn[1] = pend_len - pn[0];
      pa[0] = pend_addr;
      pa[1] = pend_addr + pn[0];
      part = miss_mask[0] ? 0 : 1;
      li = install_line(pa[part]);
      line_to_word(li, pa[part] % LB, pn[part], part ? pn[0] : 0, pend_data);
      miss_mask[part] = 1'b0;
      if (miss_mask == 0) push_res(swtc_pkg::KIND_DATA, pend_addr, pend_data, pend_len, 1);
      return;
    end
    if (it.mode >= swtc_pkg::MODE_FILL || len < swtc_pkg::LEN_MIN || len > swtc_pkg::LEN_MAX)
    begin
      push_res(swtc_pkg::KIND_REJECT, 0, 0, 0, 1);
      return;
    end
    pn[0] = (len < LB - it.address % LB) ? len : LB - it.address % LB;
    pn[1] = len - pn[0];
    pa[0] = it.address;
    pa[1] = it.address + pn[0];
    parts = pn[1] ? 2 : 1;
    if (it.mode == swtc_pkg::MODE_WRITE) begin
      for (int p = 0; p < parts; p++) begin
        li = find_way(pa[p]);
        if (li >= 0) word_to_line(li, pa[p] % LB, pn[p], p ? pn[0] : 0, it.write_data);
      end
      push_res(swtc_pkg::KIND_WRITE, it.address,
               len >= 4 ? it.write_data : it.write_data & ((32'd1 << (8*len)) - 1), len, 1);
      return;
    end
    pend_data = 0;
    miss_mask = 0;
    for (int p = 0; p < parts; p++) begin
      li = find_way(pa[p]);
      if (li >= 0) line_to_word(li, pa[p] % LB, pn[p], p ? pn[0] : 0, pend_data);
      else miss_mask[p] = 1'b1;
    end
    if (miss_mask == 0) begin
      push_res(swtc_pkg::KIND_DATA, it.address, pend_data, len, 1);
      return;
    end
    pend_addr = it.address;
    pend_len = len;
    fill_cnt = 0;
    for (int p = 0; p < parts; p++)
      if (miss_mask[p])
        push_res(swtc_pkg::KIND_FETCH, pa[p] - pa[p] % LB, 0, 0,
                 (p == 1 || !miss_mask[1]) ? 1'b1 : 1'b0);
  endfunction

  // Driver
  int src_gap = 0;
  initial begin
    in_ch.valid = 0; in_ch.mode = 0; in_ch.address = 0; in_ch.length = 0;
    in_ch.write_data = 0; in_ch.fill_word = 0; out_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) predict_cache(access_t'({in_ch.mode, in_ch.address,
        in_ch.length, in_ch.write_data, in_ch.fill_word}));
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          access_t it;
          it = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= it.mode; in_ch.address <= it.address; in_ch.length <= it.length;
          in_ch.write_data <= it.write_data; in_ch.fill_word <= it.fill_word;
          if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 10);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and sink stalls
  int sink_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        result_t got;
        got = {out_ch.kind, out_ch.out_address, out_ch.out_data, out_ch.out_length,
               out_ch.last};
        if (expected_results.size() == 0) report("unexpected", got, got);
        else begin
          result_t e;
          e = expected_results.pop_front();
          if (got !== e) report("field", got, e);
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 10);
      end
    end
  end

  // Stimulus helpers
  function automatic void add_acc(logic [1:0] m, logic [31:0] a, logic [2:0] n, logic [31:0] d);
    access_t it;
    it.mode = m; it.address = a; it.length = n; it.write_data = d; it.fill_word = $urandom;
    pending_items.push_back(it);
  endfunction

  function automatic void add_fills(int n);
    for (int i = 0; i < n; i++) add_acc(swtc_pkg::MODE_FILL, $urandom, 3'($urandom), $urandom);
  endfunction

  // Read that misses: words enough for each block fetched
  function automatic void add_read_fill(logic [31:0] a, logic [2:0] n, int blocks);
    add_acc(swtc_pkg::MODE_READ, a, n, $urandom);
    add_fills(blocks * WPL);
  endfunction

  logic [31:0] pool[8];

  initial begin
    for (int i = 0; i < LINES; i++) cl_valid[i] = 0;
    lfsr = swtc_pkg::LFSR_SEED; miss_mask = 0; fill_cnt = 0; pend_addr = 0; pend_len = 0;
    pend_data = 0;
    // Directed: extremes, spans, wrap, rejections
    add_acc(swtc_pkg::MODE_FILL, 0, 1, 0);
    add_acc(2'd3, 0, 1, 0);
    add_acc(swtc_pkg::MODE_READ, 0, 0, 0);
    add_acc(swtc_pkg::MODE_WRITE, 0, 5, 0);
    add_acc(swtc_pkg::MODE_WRITE, 0, 7, 32'hFFFFFFFF);
    add_acc(swtc_pkg::MODE_WRITE, 32'hFFFFFFFF, 4, 32'hA5A5A5A5);
    add_read_fill(32'h0000_0000, 4, 1);
    add_acc(swtc_pkg::MODE_READ, 32'h0000_0000, 4, 0);
    add_acc(swtc_pkg::MODE_WRITE, 32'h0000_0002, 2, 32'hDEADBEEF);
    add_acc(swtc_pkg::MODE_READ, 32'h0000_0001, 3, 0);
    add_read_fill(32'h0000_003E, 4, 1);
    add_read_fill(32'hFFFF_FFFE, 4, 2);
    add_acc(swtc_pkg::MODE_READ, 32'hFFFF_FFFF, 2, 0);
    add_acc(swtc_pkg::MODE_READ, 32'h0000_1000, 1, 0);
    add_acc(swtc_pkg::MODE_WRITE, 32'h0000_1000, 1, 0);
    add_fills(WPL);
    // Same set, many tags: forces LFSR replacement
    for (int t = 0; t < 10; t++) add_read_fill({t[18:0], 7'd5, 6'd8}, 2, 1);
    // Random: small pool of hot lines so hits and spans occur
    for (int i = 0; i < 8; i++)
      pool[i] = {19'($urandom_range(0, 11)), 7'($urandom_range(0, 3)), 6'd0};
    pool[7] = 32'hFFFFFFC0;
    for (int i = 0; i < 48; i++) begin
      logic [31:0] a;
      logic [2:0] n;
      int r;
      a = pool[$urandom_range(0, 7)] + $urandom_range(0, 63);
      if ($urandom_range(0, 9) == 0) a = $urandom;
      n = 3'($urandom_range(1, 4));
      r = $urandom_range(0, 19);
      if (r < 9) begin
        add_acc(swtc_pkg::MODE_READ, a, n, $urandom);
        // fetch words are supplied speculatively; extras are rejected harmlessly
        if ($urandom_range(0, 2) != 0) add_fills(WPL * (((a % LB) + n > LB) ? 2 : 1));
      end else if (r < 17) add_acc(swtc_pkg::MODE_WRITE, a, n, $urandom);
      else if (r < 19) add_acc(swtc_pkg::MODE_FILL, $urandom, 3'($urandom), $urandom);
      else add_acc(2'($urandom_range(0, 3)), $urandom, 3'($urandom_range(0, 7)), $urandom);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() < 200);
    calm = 1;
    wait (pending_items.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/swtc_pkg.sv
design/swtc_in_if.sv
design/swtc_out_if.sv
design/swtc_front.sv
design/swtc_back.sv
design/set_assoc_write_through_cache_top.sv
sim/set_assoc_write_through_cache_top_tb.sv
